### rtl/wer_pkg.sv
// shared types, constants and helpers for the write entry ring with offset lookup
`default_nettype none

package wer_pkg;

  localparam int ENTRIES     = 16;
  localparam int SIZE_BITS   = 16;
  localparam int HANDLE_BITS = 32;

  localparam int PTR_BITS    = $clog2(ENTRIES);
  localparam int OFFSET_BITS = 20;
  localparam int SUM_BITS    = SIZE_BITS + PTR_BITS;
  localparam int CMP_BITS    = ((SUM_BITS > OFFSET_BITS) ? SUM_BITS : OFFSET_BITS) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] entry_handle;
    logic [15:0] entry_size;
    logic [19:0] char_pos;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  slot_index;
    logic [15:0] byte_offset;
    logic [31:0] found_handle;
    logic        evicted;
    logic [31:0] evicted_handle;
  } res_t;

  // classified command handed from the front to the back
  typedef struct packed {
    logic                   is_find;
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
    logic [OFFSET_BITS-1:0] offset;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] p);
    logic [PTR_BITS-1:0] n;
    n = (p == PTR_BITS'(ENTRIES - 1)) ? '0 : PTR_BITS'(p + 1'b1);
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/wer_front.sv
// front: accepts request beats, classifies them and queues commands for the back
`default_nettype none

module wer_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire wer_pkg::req_t request,
  output logic               busy,
  output logic               cmd_valid,
  output wer_pkg::cmd_t      cmd,
  input  wire logic          cmd_take
);

  wer_pkg::cmd_t                   q [wer_pkg::QUEUE_DEPTH];
  logic [wer_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [wer_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [wer_pkg::QCNT_BITS-1:0]   count;
  logic                            push;
  logic                            pop;
  wer_pkg::cmd_t                   in_cmd;

  assign busy      = (count == wer_pkg::QCNT_BITS'(wer_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign push      = start && !busy;
  assign pop       = cmd_take && cmd_valid;

  // classify the beat and cast it to the stored widths
  always_comb begin
    in_cmd.is_find = (request.operation == wer_pkg::OP_FIND);
    in_cmd.handle  = wer_pkg::HANDLE_BITS'(request.entry_handle);
    in_cmd.size    = wer_pkg::SIZE_BITS'(request.entry_size);
    in_cmd.offset  = request.char_pos;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == wer_pkg::QPTR_BITS'(wer_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wer_pkg::QPTR_BITS'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == wer_pkg::QPTR_BITS'(wer_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wer_pkg::QPTR_BITS'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= wer_pkg::QCNT_BITS'(count + 1'b1);
      end else if (pop && !push) begin
        count <= wer_pkg::QCNT_BITS'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/wer_back.sv
// back: ring storage, add execution and the slot-by-slot find walk
`default_nettype none

module wer_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire wer_pkg::cmd_t cmd,
  output logic               cmd_take,
  output logic               done,
  output wer_pkg::res_t      result
);

  wer_pkg::state_t state, state_next;

  logic [wer_pkg::HANDLE_BITS-1:0] handles [wer_pkg::ENTRIES];
  logic [wer_pkg::SIZE_BITS-1:0]   sizes   [wer_pkg::ENTRIES];
  logic [wer_pkg::ENTRIES-1:0]     slot_valid;

  logic [wer_pkg::PTR_BITS-1:0]    write_pointer, write_pointer_next;
  logic [wer_pkg::PTR_BITS-1:0]    read_pointer, read_pointer_next;
  logic                            ring_full, ring_full_next;

  logic [wer_pkg::PTR_BITS-1:0]    walk_ptr, walk_ptr_next;
  logic [wer_pkg::PTR_BITS-1:0]    walk_cnt, walk_cnt_next;
  logic [wer_pkg::SUM_BITS-1:0]    sum, sum_next;
  logic [wer_pkg::OFFSET_BITS-1:0] offset, offset_next;

  logic                            done_next;
  wer_pkg::res_t                   result_next;

  logic                            wr_en;
  logic [wer_pkg::PTR_BITS-1:0]    rd_idx;
  logic [wer_pkg::HANDLE_BITS-1:0] rd_handle;
  logic [wer_pkg::SIZE_BITS-1:0]   rd_size;
  logic                            hit;

  // one read port: write slot while idle, walk slot while walking
  assign rd_idx    = (state == wer_pkg::ST_IDLE) ? write_pointer : walk_ptr;
  assign rd_handle = slot_valid[rd_idx] ? handles[rd_idx] : '0;
  assign rd_size   = slot_valid[rd_idx] ? sizes[rd_idx] : '0;
  assign hit       = (wer_pkg::CMP_BITS'(offset) <
                      wer_pkg::CMP_BITS'(sum) + wer_pkg::CMP_BITS'(rd_size));

  always_comb begin
    state_next         = state;
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    ring_full_next     = ring_full;
    walk_ptr_next      = walk_ptr;
    walk_cnt_next      = walk_cnt;
    sum_next           = sum;
    offset_next        = offset;
    done_next          = 1'b0;
    result_next        = '0;
    wr_en              = 1'b0;
    cmd_take           = 1'b0;
    unique case (state)
      wer_pkg::ST_IDLE: begin
        cmd_take = cmd_valid;
        if (cmd_valid) begin
          if (cmd.is_find) begin
            walk_ptr_next = read_pointer;
            walk_cnt_next = '0;
            sum_next      = '0;
            offset_next   = cmd.offset;
            state_next    = wer_pkg::ST_WALK;
          end else begin
            wr_en                      = 1'b1;
            done_next                  = 1'b1;
            result_next.evicted        = ring_full;
            result_next.evicted_handle = ring_full ? 32'(rd_handle) : '0;
            write_pointer_next         = wer_pkg::next_slot(write_pointer);
            if (ring_full) begin
              read_pointer_next = write_pointer_next;
            end else begin
              ring_full_next = (write_pointer_next == read_pointer);
            end
          end
        end
      end
      wer_pkg::ST_WALK: begin
        if (hit) begin
          done_next                = 1'b1;
          result_next.found        = 1'b1;
          result_next.slot_index   = 4'(walk_ptr);
          result_next.byte_offset  = 16'(wer_pkg::CMP_BITS'(offset) -
                                         wer_pkg::CMP_BITS'(sum));
          result_next.found_handle = 32'(rd_handle);
          state_next               = wer_pkg::ST_IDLE;
        end else begin
          sum_next      = wer_pkg::SUM_BITS'(sum + wer_pkg::SUM_BITS'(rd_size));
          walk_ptr_next = wer_pkg::next_slot(walk_ptr);
          walk_cnt_next = wer_pkg::PTR_BITS'(walk_cnt + 1'b1);
          if (walk_cnt == wer_pkg::PTR_BITS'(wer_pkg::ENTRIES - 1)) begin
            done_next  = 1'b1;
            state_next = wer_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = wer_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wer_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      ring_full     <= 1'b0;
      slot_valid    <= '0;
      done          <= 1'b0;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      ring_full     <= ring_full_next;
      done          <= done_next;
      if (wr_en) begin
        slot_valid[write_pointer] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_ptr <= walk_ptr_next;
    walk_cnt <= walk_cnt_next;
    sum      <= sum_next;
    offset   <= offset_next;
    result   <= result_next;
    if (wr_en) begin
      handles[write_pointer] <= cmd.handle;
      sizes[write_pointer]   <= cmd.size;
    end
  end

endmodule

`default_nettype wire

### rtl/write_entry_ring_with_offset_lookup_unit.sv
// top level of the write entry ring with offset lookup
// add path: an accepted add beat is registered in the front queue, then the idle back registers its strobe
// a find beat walks the ring from the oldest slot up to its strobe, one ring slot examined per cycle
// throughput: the back executes one add per cycle while idle; a find holds it in the walk
// slot by slot over the size store until a hit or the last slot; a 2-entry queue absorbs beats meanwhile
// reset: pointers, full flag, slot valid bits and queue are cleared together, no sweep;
// start is honored the cycle after rst falls; results cannot be stalled by the receiver
`default_nettype none

module write_entry_ring_with_offset_lookup_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire wer_pkg::req_t request,
  output logic               busy,
  output logic               done,
  output wer_pkg::res_t      result
);

  // front to back command channel
  logic          cmd_valid;
  logic          cmd_take;
  wer_pkg::cmd_t cmd;

  // front: takes a beat whenever its queue has room, even while a find walks
  wer_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: owns the ring, pops a command only when idle, drives the result register
  wer_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .done      (done),
    .result    (result)
  );

endmodule

`default_nettype wire

### rtl/wer_chk.sv
// port-level checker for the write entry ring unit, with its bind
`default_nettype none

module wer_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire wer_pkg::res_t result
);

  // beats accepted and not yet answered
  logic [2:0] pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= 3'(pend + {2'b00, (start && !busy)} - {2'b00, done});
    end
  end

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    done |-> (pend != '0))
    else $error("result strobe without an outstanding beat");

  a_idle_not_busy: assert property (@(posedge clk) disable iff (rst)
    (pend == '0) |-> !busy)
    else $error("busy while nothing is outstanding");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted beat");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.found && result.evicted))
    else $error("result marks both a find hit and an eviction");

endmodule

bind write_entry_ring_with_offset_lookup_unit wer_chk u_wer_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

### sim/tb_write_entry_ring_with_offset_lookup_unit.sv
// testbench for the write entry ring with offset lookup: directed and random add/find beats
`timescale 1ns / 100ps

module tb_write_entry_ring_with_offset_lookup_unit;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_BEATS  = 1700;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = wer_pkg::ENTRIES + 8;
  localparam int MAX_PRINTED   = 40;
  localparam int MAX_OFFSET    = (1 << wer_pkg::OFFSET_BITS) - 1;

  // ring model plus the queue of responses it has promised
  class ring_scoreboard;
    logic [wer_pkg::HANDLE_BITS-1:0] slot_handle [wer_pkg::ENTRIES];
    logic [wer_pkg::SIZE_BITS-1:0]   slot_bytes  [wer_pkg::ENTRIES];
    logic [wer_pkg::PTR_BITS-1:0]    wr_slot;
    logic [wer_pkg::PTR_BITS-1:0]    rd_slot;
    logic                            ring_full;
    wer_pkg::res_t                   expected_responses [$];
    int                              mismatches;

    function new();
      for (int k = 0; k < wer_pkg::ENTRIES; k++) begin
        slot_handle[k] = '0;
        slot_bytes[k]  = '0;
      end
      wr_slot    = '0;
      rd_slot    = '0;
      ring_full  = 1'b0;
      mismatches = 0;
    endfunction

    function logic [wer_pkg::PTR_BITS-1:0] step_slot(logic [wer_pkg::PTR_BITS-1:0] p);
      return (p == wer_pkg::PTR_BITS'(wer_pkg::ENTRIES - 1)) ?
             '0 : wer_pkg::PTR_BITS'(p + 1);
    endfunction

    // bytes held by the whole ring, summed over every slot from slot zero up
    function int unsigned stored_bytes();
      int unsigned total;
      total = 0;
      for (int k = 0; k < wer_pkg::ENTRIES; k++) total += slot_bytes[k];
      return total;
    endfunction

    // updates the ring copy and returns the response this command must give
    function wer_pkg::res_t predict_ring_response(wer_pkg::req_t cmd);
      wer_pkg::res_t                resp;
      int unsigned                  run;
      logic [wer_pkg::PTR_BITS-1:0] p;
      logic                         hit;
      resp = '0;
      if (cmd.operation == wer_pkg::OP_ADD) begin
        if (ring_full) begin
          resp.evicted        = 1'b1;
          resp.evicted_handle = slot_handle[wr_slot];
        end
        slot_handle[wr_slot] = cmd.entry_handle;
        slot_bytes[wr_slot]  = cmd.entry_size;
        wr_slot = step_slot(wr_slot);
        if (ring_full) rd_slot = wr_slot;
        else ring_full = (wr_slot == rd_slot);
      end else begin
        run = 0;
        p   = rd_slot;
        hit = 1'b0;
        for (int k = 0; k < wer_pkg::ENTRIES; k++) begin
          if (!hit) begin
            if (cmd.char_pos < run + slot_bytes[p]) begin
              hit               = 1'b1;
              resp.found        = 1'b1;
              resp.slot_index   = p;
              resp.byte_offset  = 16'(cmd.char_pos - run);
              resp.found_handle = slot_handle[p];
            end else begin
              run += slot_bytes[p];
              p = step_slot(p);
            end
          end
        end
      end
      return resp;
    endfunction

    function void note_command(wer_pkg::req_t cmd);
      expected_responses.push_back(predict_ring_response(cmd));
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
      if (mismatches < MAX_PRINTED)
        $display("%0t mismatch: %s expected %0h got %0h", $time, what, want, got);
      mismatches++;
    endtask

    task check_response(wer_pkg::res_t got);
      wer_pkg::res_t want;
      if (expected_responses.size() == 0) begin
        report("response with none outstanding", 64'd0, 64'(got));
      end else begin
        want = expected_responses.pop_front();
        if (got.found !== want.found)
          report("found", 64'(want.found), 64'(got.found));
        if (got.slot_index !== want.slot_index)
          report("slot_index", 64'(want.slot_index), 64'(got.slot_index));
        if (got.byte_offset !== want.byte_offset)
          report("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
        if (got.found_handle !== want.found_handle)
          report("found_handle", 64'(want.found_handle), 64'(got.found_handle));
        if (got.evicted !== want.evicted)
          report("evicted", 64'(want.evicted), 64'(got.evicted));
        if (got.evicted_handle !== want.evicted_handle)
          report("evicted_handle", 64'(want.evicted_handle), 64'(got.evicted_handle));
      end
    endtask
  endclass

  logic          clk;
  logic          rst;
  logic          start;
  wer_pkg::req_t request;
  logic          busy;
  logic          done;
  wer_pkg::res_t result;

  ring_scoreboard sb;
  int             burst_left;
  int             idle_cycles;

  write_entry_ring_with_offset_lookup_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // response side: the block cannot be held off, so every strobe is checked as it comes
  // watchdog: any cycle with no accepted beat in either direction counts toward the limit
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) sb.check_response(result);
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // hold one command on the port until the block takes it; start stays high so that
  // back-to-back beats never lower and raise it within one step
  task issue(wer_pkg::req_t cmd);
    int gap;
    if (burst_left == 0) begin
      // end of a burst: drop start for a random gap, sometimes none at all
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    request <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(cmd);
  endtask

  // sender hold-off: nothing new until every promised response is back
  task hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function wer_pkg::req_t add_cmd(logic [31:0] handle, logic [15:0] bytes);
    wer_pkg::req_t cmd;
    cmd.operation    = wer_pkg::OP_ADD;
    cmd.entry_handle = handle;
    cmd.entry_size   = bytes;
    cmd.char_pos     = 20'($urandom());
    return cmd;
  endfunction

  function wer_pkg::req_t find_cmd(int unsigned offset);
    wer_pkg::req_t cmd;
    cmd.operation    = wer_pkg::OP_FIND;
    cmd.entry_handle = $urandom();
    cmd.entry_size   = 16'($urandom());
    cmd.char_pos     = 20'(offset);
    return cmd;
  endfunction

  // random beat: mostly small entries so finds land inside stored data,
  // with occasional full-range sizes and offsets to toggle every bit
  function wer_pkg::req_t random_cmd();
    int unsigned held;
    logic [15:0] bytes;
    int unsigned offset;
    held = sb.stored_bytes();
    if (held > MAX_OFFSET) held = MAX_OFFSET;
    if ($urandom_range(99) < 45) begin
      case ($urandom_range(9))
        0:       bytes = 16'($urandom());
        1:       bytes = '0;
        default: bytes = 16'($urandom_range(1, 40));
      endcase
      return add_cmd($urandom(), bytes);
    end
    case ($urandom_range(9))
      0:       offset = $urandom_range(MAX_OFFSET);
      1:       offset = held;
      2:       offset = (held > 0) ? held - 1 : 0;
      default: offset = (held > 0) ? $urandom_range(held - 1) : 0;
    endcase
    return find_cmd(offset);
  endfunction

  initial begin
    sb          = new();
    burst_left  = 0;
    idle_cycles = 0;
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty ring: nothing can be found, not even offset zero
    issue(find_cmd(0));
    issue(find_cmd(MAX_OFFSET));
    // extreme handles and sizes, including a zero-byte entry that finds must skip
    issue(add_cmd(32'h0000_0000, 16'h0000));
    issue(add_cmd(32'hffff_ffff, 16'hffff));
    issue(add_cmd(32'haaaa_aaaa, 16'h0001));
    issue(find_cmd(0));
    issue(find_cmd(16'hfffe));
    issue(find_cmd(16'hffff));
    issue(find_cmd(32'h1_0000));
    issue(find_cmd(MAX_OFFSET));
    // fill with maximal entries past the ring's capacity so the oldest get evicted
    for (int k = 0; k < wer_pkg::ENTRIES; k++) issue(add_cmd(32'h5555_5555 ^ k, 16'hffff));
    issue(find_cmd(wer_pkg::ENTRIES * 16'hffff - 1));
    issue(find_cmd(MAX_OFFSET));
    issue(find_cmd(0));
    hold_until_drained();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      issue(random_cmd());
      if (n == RANDOM_BEATS / 2) hold_until_drained();
    end

    // drain: the watchdog bounds this wait
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### write_entry_ring_with_offset_lookup_unit.f
rtl/wer_pkg.sv
rtl/wer_front.sv
rtl/wer_back.sv
rtl/write_entry_ring_with_offset_lookup_unit.sv
rtl/wer_chk.sv
sim/tb_write_entry_ring_with_offset_lookup_unit.sv
